// ===== hdl/ddes_pkg.sv =====
`timescale 1ns / 1ps
package ddes_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_ITERS  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  localparam logic [31:0] INV_TWO_PI_Q32  = 32'd683565276;
  localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;

  // configuration register indexes
  localparam logic [3:0] REG_FRICTION   = 4'd0;
  localparam logic [3:0] REG_TORQUE     = 4'd1;
  localparam logic [3:0] REG_VOLTAGE    = 4'd2;
  localparam logic [3:0] REG_TIME_STEP  = 4'd3;
  localparam logic [3:0] REG_HALF_RAD   = 4'd4;
  localparam logic [3:0] REG_TURN_RATE  = 4'd5;
  localparam logic [3:0] REG_START_X    = 4'd6;
  localparam logic [3:0] REG_START_Y    = 4'd7;

  localparam logic [31:0] RST_FRICTION  = 32'd104259;
  localparam logic [31:0] RST_TORQUE    = 32'd167772;
  localparam logic [31:0] RST_VOLTAGE   = 32'd479349;
  localparam logic [31:0] RST_TIME_STEP = 32'd2147484;
  localparam logic [30:0] RST_HALF_RAD  = 31'd16384;
  localparam logic [31:0] RST_TURN_RATE = 32'd222514;
  localparam logic [31:0] RST_START_X   = 32'd131072;
  localparam logic [31:0] RST_START_Y   = 32'd131072;

  // micro-op sequence of the multiply unit
  localparam logic [4:0] OP_FR_R = 5'd0;
  localparam logic [4:0] OP_TR_R = 5'd1;
  localparam logic [4:0] OP_VR_R = 5'd2;
  localparam logic [4:0] OP_DW_R = 5'd3;
  localparam logic [4:0] OP_FR_L = 5'd4;
  localparam logic [4:0] OP_TR_L = 5'd5;
  localparam logic [4:0] OP_VR_L = 5'd6;
  localparam logic [4:0] OP_DW_L = 5'd7;
  localparam logic [4:0] OP_RA_R = 5'd8;
  localparam logic [4:0] OP_AD_R = 5'd9;
  localparam logic [4:0] OP_RA_L = 5'd10;
  localparam logic [4:0] OP_AD_L = 5'd11;
  localparam logic [4:0] OP_VEL  = 5'd12;
  localparam logic [4:0] OP_HRT  = 5'd13;
  localparam logic [4:0] OP_HDT  = 5'd14;
  localparam logic [4:0] OP_VC   = 5'd15;
  localparam logic [4:0] OP_XD   = 5'd16;
  localparam logic [4:0] OP_VS   = 5'd17;
  localparam logic [4:0] OP_YD   = 5'd18;

  localparam logic [2:0] PH_LOAD  = 3'd0;
  localparam logic [2:0] PH_LO    = 3'd1;
  localparam logic [2:0] PH_HI    = 3'd2;
  localparam logic [2:0] PH_SUM   = 3'd3;
  localparam logic [2:0] PH_APPLY = 3'd4;

  typedef struct packed {
    logic signed [15:0] right_voltage;
    logic signed [15:0] left_voltage;
    logic signed [15:0] right_load;
    logic signed [15:0] left_load;
    logic               restart;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading;
    logic        [31:0] right_angle;
    logic        [31:0] left_angle;
    logic signed [31:0] right_rate;
    logic signed [31:0] left_rate;
  } out_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/diff_drive_euler_step_unit.sv =====
`timescale 1ns / 1ps
// Accepts one word at a time: the single 32x32 multiplier runs 19 micro-ops,
// each through the load, low-limb, high-limb, sum and apply phases, after the
// serial CORDIC; a restart word goes straight to the output state.
// Reset (rst_n low, synchronous) loads register defaults, start position,
// zero heading, angles and speeds, and empties the output register.
module diff_drive_euler_step_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ddes_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ddes_pkg::out_t      out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CORD = 4'b0010,
    S_MATH = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] k1_r, k2_r, k3_r, dt_r, trg_r;
  logic [30:0] hrad_r;
  logic [31:0] sx_r, sy_r;

  ddes_pkg::in_t in_r;
  logic signed [31:0] x_r, y_r, wr_r, wl_r, nwr_r, nwl_r;
  logic [31:0] hd_r, ar_r, al_r;

  logic signed [33:0] cx_r, cy_r, cz_r;
  logic flip_r;
  logic [4:0] cnt_r;

  logic [4:0] op_r;
  logic [2:0] ph_r;
  logic [57:0] mag_a_r;
  logic [31:0] mag_b_r;
  logic neg_r;
  logic [5:0] sh_r;
  logic [63:0] p0_r;
  logic [57:0] p1_r;
  logic signed [63:0] res_r, acc_r, tmp_r, v_r;

  ddes_pkg::out_t out_r;
  logic out_valid_r;

  logic in_acc, last_iter, op_done;
  logic signed [33:0] dx, dy, at, z0, cos_v, sin_v;
  logic signed [63:0] wr_x, wl_x, a_sel, a_abs;
  logic [31:0] b_sel;
  logic b_neg;
  logic [5:0] sh_sel;
  logic [31:0] mul_a;
  logic [63:0] mul_p;
  logic [89:0] full_sum, shifted;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign last_iter = (cnt_r == 5'(ddes_pkg::CORDIC_ITERS - 1));
  assign op_done   = (ph_r == ddes_pkg::PH_APPLY) && (op_r == ddes_pkg::OP_YD);

  // CORDIC micro-rotation
  assign dx = cx_r >>> cnt_r;
  assign dy = cy_r >>> cnt_r;
  assign at = {2'b00, ddes_pkg::atan_turn(cnt_r)};
  assign z0 = {{2{hd_r[31]}}, hd_r};
  assign cos_v = flip_r ? -cx_r : cx_r;
  assign sin_v = flip_r ? -cy_r : cy_r;

  assign wr_x = {{32{wr_r[31]}}, wr_r};
  assign wl_x = {{32{wl_r[31]}}, wl_r};

  always_comb begin
    a_sel  = '0;
    b_sel  = '0;
    b_neg  = 1'b0;
    sh_sel = 6'd0;
    case (op_r)
      ddes_pkg::OP_FR_R: begin a_sel = wr_x; b_sel = k1_r; sh_sel = 6'd8; end
      ddes_pkg::OP_TR_R: begin a_sel = 64'(in_r.right_load); b_sel = k2_r; end
      ddes_pkg::OP_VR_R: begin a_sel = 64'(in_r.right_voltage); b_sel = k3_r; end
      ddes_pkg::OP_DW_R: begin a_sel = acc_r; b_sel = dt_r; sh_sel = 6'd48; end
      ddes_pkg::OP_FR_L: begin a_sel = wl_x; b_sel = k1_r; sh_sel = 6'd8; end
      ddes_pkg::OP_TR_L: begin a_sel = 64'(in_r.left_load); b_sel = k2_r; end
      ddes_pkg::OP_VR_L: begin a_sel = 64'(in_r.left_voltage); b_sel = k3_r; end
      ddes_pkg::OP_DW_L: begin a_sel = acc_r; b_sel = dt_r; sh_sel = 6'd48; end
      ddes_pkg::OP_RA_R: begin
        a_sel = wr_x; b_sel = ddes_pkg::INV_TWO_PI_Q32; sh_sel = 6'd16;
      end
      ddes_pkg::OP_AD_R: begin a_sel = tmp_r; b_sel = dt_r; sh_sel = 6'd32; end
      ddes_pkg::OP_RA_L: begin
        a_sel = wl_x; b_sel = ddes_pkg::INV_TWO_PI_Q32; sh_sel = 6'd16;
      end
      ddes_pkg::OP_AD_L: begin a_sel = tmp_r; b_sel = dt_r; sh_sel = 6'd32; end
      ddes_pkg::OP_VEL: begin
        a_sel = wr_x + wl_x; b_sel = {1'b0, hrad_r}; sh_sel = 6'd16;
      end
      ddes_pkg::OP_HRT: begin a_sel = wr_x - wl_x; b_sel = trg_r; sh_sel = 6'd8; end
      ddes_pkg::OP_HDT: begin a_sel = tmp_r; b_sel = dt_r; sh_sel = 6'd32; end
      ddes_pkg::OP_VC: begin
        a_sel = v_r; b_neg = cos_v[33]; sh_sel = 6'd30;
        b_sel = cos_v[33] ? 32'(-cos_v) : cos_v[31:0];
      end
      ddes_pkg::OP_XD: begin a_sel = tmp_r; b_sel = dt_r; sh_sel = 6'd32; end
      ddes_pkg::OP_VS: begin
        a_sel = v_r; b_neg = sin_v[33]; sh_sel = 6'd30;
        b_sel = sin_v[33] ? 32'(-sin_v) : sin_v[31:0];
      end
      ddes_pkg::OP_YD: begin a_sel = tmp_r; b_sel = dt_r; sh_sel = 6'd32; end
      default: begin a_sel = '0; end
    endcase
  end

  assign a_abs = a_sel[63] ? -a_sel : a_sel;

  // shared 32x32 multiplier: low limb then high limb of the magnitude
  assign mul_a    = (ph_r == ddes_pkg::PH_HI) ? {6'd0, mag_a_r[57:32]} : mag_a_r[31:0];
  assign mul_p    = mul_a * mag_b_r;
  assign full_sum = {p1_r, 32'd0} + {26'd0, p0_r};
  assign shifted  = full_sum >> sh_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = in_data.restart ? S_DONE : S_CORD;
      S_CORD: if (last_iter) state_nxt = S_MATH;
      S_MATH: if (op_done) state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k1_r   <= ddes_pkg::RST_FRICTION;
      k2_r   <= ddes_pkg::RST_TORQUE;
      k3_r   <= ddes_pkg::RST_VOLTAGE;
      dt_r   <= ddes_pkg::RST_TIME_STEP;
      hrad_r <= ddes_pkg::RST_HALF_RAD;
      trg_r  <= ddes_pkg::RST_TURN_RATE;
      sx_r   <= ddes_pkg::RST_START_X;
      sy_r   <= ddes_pkg::RST_START_Y;
      x_r    <= ddes_pkg::RST_START_X;
      y_r    <= ddes_pkg::RST_START_Y;
      hd_r   <= '0;
      ar_r   <= '0;
      al_r   <= '0;
      wr_r   <= '0;
      wl_r   <= '0;
      cnt_r  <= '0;
      op_r   <= '0;
      ph_r   <= ddes_pkg::PH_LOAD;
    end else begin
      state_r <= state_nxt;
      // in S_DONE the output register is refilled below instead
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;

      if (cfg_valid) begin
        case (cfg_index)
          ddes_pkg::REG_FRICTION:  k1_r   <= cfg_data;
          ddes_pkg::REG_TORQUE:    k2_r   <= cfg_data;
          ddes_pkg::REG_VOLTAGE:   k3_r   <= cfg_data;
          ddes_pkg::REG_TIME_STEP: dt_r   <= cfg_data;
          ddes_pkg::REG_HALF_RAD:  hrad_r <= cfg_data[30:0];
          ddes_pkg::REG_TURN_RATE: trg_r  <= cfg_data;
          ddes_pkg::REG_START_X:   sx_r   <= cfg_data;
          ddes_pkg::REG_START_Y:   sy_r   <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            in_r  <= in_data;
            cnt_r <= '0;
            if (in_data.restart) begin
              x_r  <= sx_r;
              y_r  <= sy_r;
              hd_r <= '0;
              ar_r <= '0;
              al_r <= '0;
              wr_r <= '0;
              wl_r <= '0;
            end else begin
              cx_r <= ddes_pkg::CORDIC_GAIN_Q30;
              cy_r <= '0;
              // fold heading into the right half-plane
              if (z0 > 34'sd1073741824) begin
                cz_r   <= z0 - 34'sd2147483648;
                flip_r <= 1'b1;
              end else if (z0 < -34'sd1073741824) begin
                cz_r   <= z0 + 34'sd2147483648;
                flip_r <= 1'b1;
              end else begin
                cz_r   <= z0;
                flip_r <= 1'b0;
              end
            end
          end
        end
        S_CORD: begin
          if (!cz_r[33]) begin
            cx_r <= cx_r - dy;
            cy_r <= cy_r + dx;
            cz_r <= cz_r - at;
          end else begin
            cx_r <= cx_r + dy;
            cy_r <= cy_r - dx;
            cz_r <= cz_r + at;
          end
          cnt_r <= cnt_r + 5'd1;
          op_r  <= ddes_pkg::OP_FR_R;
          ph_r  <= ddes_pkg::PH_LOAD;
        end
        S_MATH: begin
          case (ph_r)
            ddes_pkg::PH_LOAD: begin
              mag_a_r <= a_abs[57:0];
              mag_b_r <= b_sel;
              neg_r   <= a_sel[63] ^ b_neg;
              sh_r    <= sh_sel;
              ph_r    <= ddes_pkg::PH_LO;
            end
            ddes_pkg::PH_LO: begin
              p0_r <= mul_p;
              ph_r <= ddes_pkg::PH_HI;
            end
            ddes_pkg::PH_HI: begin
              p1_r <= mul_p[57:0];
              ph_r <= ddes_pkg::PH_SUM;
            end
            ddes_pkg::PH_SUM: begin
              res_r <= neg_r ? -$signed(shifted[63:0]) : $signed(shifted[63:0]);
              ph_r  <= ddes_pkg::PH_APPLY;
            end
            ddes_pkg::PH_APPLY: begin
              ph_r <= ddes_pkg::PH_LOAD;
              op_r <= op_r + 5'd1;
              case (op_r)
                ddes_pkg::OP_FR_R, ddes_pkg::OP_FR_L: acc_r <= -res_r;
                ddes_pkg::OP_TR_R, ddes_pkg::OP_TR_L: acc_r <= acc_r - res_r;
                ddes_pkg::OP_VR_R, ddes_pkg::OP_VR_L: acc_r <= acc_r + res_r;
                ddes_pkg::OP_DW_R: nwr_r <= ddes_pkg::sat32(wr_x + res_r);
                ddes_pkg::OP_DW_L: nwl_r <= ddes_pkg::sat32(wl_x + res_r);
                ddes_pkg::OP_AD_R: ar_r <= ar_r + res_r[31:0];
                ddes_pkg::OP_AD_L: al_r <= al_r + res_r[31:0];
                ddes_pkg::OP_VEL:  v_r  <= res_r;
                ddes_pkg::OP_HDT:  hd_r <= hd_r + res_r[31:0];
                ddes_pkg::OP_XD:
                  x_r <= ddes_pkg::sat32({{32{x_r[31]}}, x_r} + res_r);
                ddes_pkg::OP_YD: begin
                  y_r  <= ddes_pkg::sat32({{32{y_r[31]}}, y_r} + res_r);
                  // speeds change only once every derivative is taken
                  wr_r <= nwr_r;
                  wl_r <= nwl_r;
                end
                default: tmp_r <= res_r;
              endcase
            end
            default: ph_r <= ddes_pkg::PH_LOAD;
          endcase
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r       <= 1'b1;
            out_r.pos_x       <= x_r;
            out_r.pos_y       <= y_r;
            out_r.heading     <= hd_r;
            out_r.right_angle <= ar_r;
            out_r.left_angle  <= al_r;
            out_r.right_rate  <= wr_r;
            out_r.left_rate   <= wl_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/ddes_chk.sv =====
`timescale 1ns / 1ps
module ddes_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ddes_pkg::out_t out_data,
  input logic           cfg_valid,
  input logic           cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in progress");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a word being worked on");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("register write stalled");

endmodule

bind diff_drive_euler_step_unit ddes_chk u_ddes_chk (.*);
